// ===== rtl/hcp_pkg.sv =====
`timescale 1ns / 1ps

package hcp_pkg;

    localparam int GRID_HALF = 15;

    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int OUT_W   = 5;

    // signed width of a scan index covering -GRID_HALF .. GRID_HALF,
    // never narrower than the output fields
    localparam int IDX_W = ($clog2(GRID_HALF + 1) + 1 > OUT_W) ?
                           ($clog2(GRID_HALF + 1) + 1) : OUT_W;

    // width of the strip sums, with headroom for the doubled terms and +/- one
    localparam int TERM_W = (IDX_W + FRAC_W + 1 > COORD_W + 1) ?
                            (IDX_W + FRAC_W + 1) : (COORD_W + 1);
    localparam int ACC_W  = TERM_W + 3;

    localparam logic signed [IDX_W-1:0] IDX_MIN = IDX_W'(-GRID_HALF);
    localparam logic signed [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_HALF);

    localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(1 << FRAC_W);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

// ===== rtl/hcp_strip_test.sv =====
`timescale 1ns / 1ps

module hcp_strip_test (
    input  logic signed [hcp_pkg::COORD_W-1:0] x,
    input  logic signed [hcp_pkg::COORD_W-1:0] y,
    input  logic signed [hcp_pkg::IDX_W-1:0]   c,
    input  logic signed [hcp_pkg::IDX_W-1:0]   r,
    output logic                               hit
);

    localparam int ACC_W   = hcp_pkg::ACC_W;
    localparam int COORD_W = hcp_pkg::COORD_W;
    localparam int IDX_W   = hcp_pkg::IDX_W;
    localparam int FRAC_W  = hcp_pkg::FRAC_W;

    logic signed [ACC_W-1:0] xs;
    logic signed [ACC_W-1:0] ys;
    logic signed [ACC_W-1:0] y2;
    logic signed [ACC_W-1:0] cu;
    logic signed [ACC_W-1:0] ru;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] d;
    logic                    in_a;
    logic                    in_b;
    logic                    in_d;

    assign xs = {{(ACC_W-COORD_W){x[COORD_W-1]}}, x};
    assign ys = {{(ACC_W-COORD_W){y[COORD_W-1]}}, y};
    assign y2 = ys <<< 1;
    assign cu = {{(ACC_W-IDX_W-FRAC_W){c[IDX_W-1]}}, c, {FRAC_W{1'b0}}};
    assign ru = {{(ACC_W-IDX_W-FRAC_W){r[IDX_W-1]}}, r, {FRAC_W{1'b0}}};

    // doubled first strip, then the two others
    assign a = cu - xs - (ru <<< 1);
    assign b = (cu <<< 1) - (xs <<< 1) - ru;
    assign d = xs - cu - ru;

    assign in_a = (y2 > a - hcp_pkg::ONE_Q) && (y2 <= a + hcp_pkg::ONE_Q);
    assign in_b = (ys > b - hcp_pkg::ONE_Q) && (ys <= b + hcp_pkg::ONE_Q);
    assign in_d = (ys > d - hcp_pkg::ONE_Q) && (ys <= d + hcp_pkg::ONE_Q);

    assign hit = in_a && in_b && in_d;

endmodule

// ===== rtl/hex_cell_pick.sv =====
`timescale 1ns / 1ps

// Point to hexagonal cell lookup. Each input beat carries a Q7.16 point; the
// block walks the candidate cells row by row (lowest row first) and column by
// column, testing one cell per clock in a single strip-test unit, and returns
// the first cell that holds the point. Points are taken in only while idle;
// the scan ends at the matching cell or after all (2*GRID_HALF+1)^2 = 961
// cells when nothing matches. The result sits in an output register, so the
// scan of the next item may start while it waits; a finished scan stalls only
// if that register is still full. When no cell matches, found is 0 and column
// and negated row are 0.
module hex_cell_pick (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x, point_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cell_col, cell_row_neg, zero pad
    output logic [0:0]  m_tuser    // found
);

    localparam int COORD_W = hcp_pkg::COORD_W;
    localparam int IDX_W   = hcp_pkg::IDX_W;
    localparam int OUT_W   = hcp_pkg::OUT_W;

    hcp_pkg::state_t state_reg, state_next;

    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [IDX_W-1:0]   c_reg, c_next;
    logic signed [IDX_W-1:0]   r_reg, r_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      found_reg, found_next;
    logic [OUT_W-1:0]          col_reg, col_next;
    logic [OUT_W-1:0]          row_reg, row_next;

    logic                      hit;
    logic                      last_cell;
    logic                      finish;
    logic                      out_free;
    logic                      s_take;
    logic signed [IDX_W-1:0]   r_neg;

    hcp_strip_test u_test (
        .x   (x_reg),
        .y   (y_reg),
        .c   (c_reg),
        .r   (r_reg),
        .hit (hit)
    );

    assign s_tready  = (state_reg == hcp_pkg::S_IDLE);
    assign s_take    = s_tvalid && s_tready;
    assign last_cell = (c_reg == hcp_pkg::IDX_MAX) && (r_reg == hcp_pkg::IDX_MAX);
    assign finish    = (state_reg == hcp_pkg::S_SCAN) && (hit || last_cell);
    assign out_free  = !m_valid_reg || m_tready;
    assign r_neg     = -r_reg;

    always_comb begin
        state_next   = state_reg;
        c_next       = c_reg;
        r_next       = r_reg;
        m_valid_next = m_valid_reg;
        found_next   = found_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            hcp_pkg::S_IDLE: begin
                if (s_take) begin
                    c_next     = hcp_pkg::IDX_MIN;
                    r_next     = hcp_pkg::IDX_MIN;
                    state_next = hcp_pkg::S_SCAN;
                end
            end
            hcp_pkg::S_SCAN: begin
                if (finish) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        found_next   = hit;
                        col_next     = hit ? c_reg[OUT_W-1:0] : '0;
                        row_next     = hit ? r_neg[OUT_W-1:0] : '0;
                        state_next   = hcp_pkg::S_IDLE;
                    end
                end else if (c_reg == hcp_pkg::IDX_MAX) begin
                    c_next = hcp_pkg::IDX_MIN;
                    r_next = r_reg + IDX_W'(1);
                end else begin
                    c_next = c_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = hcp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hcp_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            x_reg <= s_tdata[COORD_W-1:0];
            y_reg <= s_tdata[2*COORD_W-1:COORD_W];
        end
        c_reg     <= c_next;
        r_reg     <= r_next;
        found_reg <= found_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-2*OUT_W){1'b0}}, row_reg, col_reg};
    assign m_tuser  = found_reg;

`ifndef SYNTH
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> (state_reg == hcp_pkg::S_SCAN) && (c_reg == hcp_pkg::IDX_MIN)
                   && (r_reg == hcp_pkg::IDX_MIN))
        else $error("scan did not start at the first cell");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !found_reg) |-> (col_reg == '0) && (row_reg == '0))
        else $error("miss result carries nonzero cell");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && out_free) |=> (state_reg == hcp_pkg::S_IDLE) && m_valid_reg)
        else $error("finished scan not delivered");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && !out_free) |=> (state_reg == hcp_pkg::S_SCAN)
                                  && $stable(c_reg) && $stable(r_reg))
        else $error("scan moved while result register full");
`endif

endmodule

// ===== test/tb_hex_cell_pick.sv =====
`timescale 1ns / 1ps

module tb_hex_cell_pick;

    localparam int  U          = 1 << hcp_pkg::FRAC_W;
    localparam int  N_RANDOM   = 620;
    localparam int  HOLD_LEN   = 3000;
    localparam int  DRAIN_WAIT = 1000;
    localparam longint LIMIT   = 3000000;

    typedef struct packed {
        logic               drain;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } point_beat_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               found;
        logic signed [4:0]  col;
        logic signed [4:0]  row_neg;
    } cell_expect_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // point_x, point_y
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // cell_col, cell_row_neg, zero pad
    logic [0:0]  m_tuser;         // found

    point_beat_t  point_q[$];
    cell_expect_t cell_q[$];

    point_beat_t  next_point;
    cell_expect_t want;
    longint       cycles = 0;
    int           errors = 0;
    int           n_sent = 0;
    int           n_results = 0;
    int           n_found = 0;
    int           send_gap = 0;
    int           rdy_stall = 0;
    int           hold_left = 0;
    int           holds_done = 0;
    int           beats_taken = 0;

    hex_cell_pick u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic cell_expect_t locate_cell(logic signed [23:0] px,
                                                 logic signed [23:0] py);
        longint       x, y, one, cu, ru, a, b, d;
        int           nr;
        cell_expect_t res;
        one = longint'(1) << hcp_pkg::FRAC_W;
        x = px;
        y = py;
        res = '0;
        res.x = px;
        res.y = py;
        // rows first, then columns; first hit wins on shared edges
        for (int r = -hcp_pkg::GRID_HALF; r <= hcp_pkg::GRID_HALF; r++) begin
            for (int c = -hcp_pkg::GRID_HALF; c <= hcp_pkg::GRID_HALF; c++) begin
                cu = c * one;
                ru = r * one;
                a = cu - x - 2 * ru;
                b = 2 * cu - 2 * x - ru;
                d = x - cu - ru;
                if (2 * y > a - one && 2 * y <= a + one &&
                    y > b - one && y <= b + one &&
                    y > d - one && y <= d + one) begin
                    nr = -r;
                    res.found = 1'b1;
                    res.col = c[4:0];
                    res.row_neg = nr[4:0];
                    return res;
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(99, 0);
        if (calm || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(4, 1);
        else
            return $urandom_range(80, 20);
    endfunction

    task automatic add_point(int x, int y);
        point_beat_t p;
        p.drain = 1'b0;
        p.x = x[23:0];
        p.y = y[23:0];
        point_q.insert(point_q.size(), p);
    endtask

    task automatic add_drain();
        point_beat_t p;
        p = '0;
        p.drain = 1'b1;
        point_q.insert(point_q.size(), p);
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d points still expected", cycles,
                     cell_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // point driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cell_q.insert(cell_q.size(), locate_cell(s_tdata[23:0], s_tdata[47:24]));
                n_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // beat still on offer
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (point_q.size() > 0 && point_q[0].drain) begin
                s_tvalid <= 1'b0;
                if (cell_q.size() == 0)
                    point_q.delete(0);
            end else if (point_q.size() > 0) begin
                next_point = point_q.pop_front();
                s_tdata <= {next_point.y, next_point.x};
                s_tvalid <= 1'b1;
                send_gap = pick_gap(cycles[9:7] == 3'd0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result ready, with two long hold-offs so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                beats_taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_done < 2 &&
                         beats_taken >= (holds_done == 0 ? 40 : 350)) begin
                hold_left = HOLD_LEN;
                holds_done++;
                m_tready <= 1'b0;
            end else if (rdy_stall > 0) begin
                rdy_stall--;
                m_tready <= 1'b0;
            end else begin
                rdy_stall = pick_gap(cycles[9:7] == 3'd4);
                m_tready <= (rdy_stall == 0);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (cell_q.size() == 0) begin
                report_mismatch($sformatf("result beat with no point outstanding: found=%0b",
                                          m_tuser[0]));
            end else begin
                want = cell_q.pop_front();
                if (want.found)
                    n_found++;
                if (m_tuser[0] !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b, x=%0d y=%0d",
                                              m_tuser[0], want.found, want.x, want.y));
                if ($signed(m_tdata[4:0]) !== want.col)
                    report_mismatch($sformatf("cell_col got %0d want %0d, x=%0d y=%0d",
                                              $signed(m_tdata[4:0]), want.col,
                                              want.x, want.y));
                if ($signed(m_tdata[9:5]) !== want.row_neg)
                    report_mismatch($sformatf("cell_row_neg got %0d want %0d, x=%0d y=%0d",
                                              $signed(m_tdata[9:5]), want.row_neg,
                                              want.x, want.y));
            end
        end
    end

    initial begin
        int          kind;
        int          span;
        int          x;
        int          y;
        logic [31:0] raw;

        // directed: center, extremes, window corners, outside, shared edges
        add_point(0, 0);
        add_point(8388607, 8388607);
        add_point(-8388608, -8388608);
        add_point(8388607, -8388608);
        add_point(-8388608, 8388607);
        add_point(15 * U, 15 * U);
        add_point(-15 * U, -15 * U);
        add_point(15 * U, -15 * U);
        add_point(-15 * U, 15 * U);
        add_point(17 * U, 0);
        add_point(0, -17 * U);
        add_point(U / 2, 0);
        add_point(0, U / 2);
        add_point(U / 2, -U / 2);
        add_point(-U / 2, U / 2);
        add_point(U / 2 + 1, 0);
        add_point(U / 2 - 1, 0);
        add_point(0, U / 2 + 1);
        add_point(U / 4, 3 * U / 4);
        add_point(-U, -U / 2);
        add_point(15 * U + U / 2, 0);
        add_point(3 * U, -7 * U + U / 2);
        add_drain();

        span = 16 * U;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300 || i == 500)
                add_drain();
            kind = $urandom_range(99, 0);
            if (kind < 60) begin
                x = int'($urandom_range(2 * span, 0)) - span;
                y = int'($urandom_range(2 * span, 0)) - span;
            end else if (kind < 80) begin
                // quarter grid lands often on strip edges
                x = (int'($urandom_range(128, 0)) - 64) * (U / 4);
                y = (int'($urandom_range(128, 0)) - 64) * (U / 4);
                if ($urandom_range(3, 0) == 0)
                    x = x + int'($urandom_range(2, 0)) - 1;
                if ($urandom_range(3, 0) == 0)
                    y = y + int'($urandom_range(2, 0)) - 1;
            end else begin
                raw = $urandom();
                x = int'(raw[23:0]);
                raw = $urandom();
                y = int'(raw[23:0]);
            end
            add_point(x, y);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (point_q.size() == 0 && !s_tvalid);
        wait (cell_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d points sent (edges, window interior, quarter grid, full range), %0d results",
                 n_sent, n_results);
        $display("%0d points inside a cell, %0d outside; %0d long output hold-offs, 3 drains",
                 n_found, n_results - n_found, holds_done);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hcp_pkg.sv
rtl/hcp_strip_test.sv
rtl/hex_cell_pick.sv
test/tb_hex_cell_pick.sv
